@@ design/fixed_block_pool_allocator_top_assert.svh @@
// assertion macros for the block pool allocator
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, quiet during reset
`define FBPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/fbpa_pkg.sv @@
`default_nettype none

package fbpa_pkg;

  localparam int NUM_BLOCKS = 256;
  localparam int INDEX_SPACE = 256;
  localparam int IDX_W = 8;
  localparam int CNT_W = 9;

  localparam logic [CNT_W-1:0] LIST_EMPTY = CNT_W'(INDEX_SPACE);
  localparam logic [CNT_W-1:0] CAP_MAX =
    CNT_W'((NUM_BLOCKS < INDEX_SPACE) ? NUM_BLOCKS : INDEX_SPACE);
  localparam logic [CNT_W-1:0] COUNT_RESET = 9'd256;
  localparam logic [CNT_W-1:0] COUNT_SAT = 9'h1FF;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // write side of the link memory
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [CNT_W-1:0] data;
  } link_wr_t;

endpackage

`default_nettype wire

@@ design/fbpa_link_ram.sv @@
`default_nettype none

module fbpa_link_ram
  import fbpa_pkg::*;
(
  input  wire logic             clk,
  input  wire link_wr_t         wr,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [CNT_W-1:0] rd_data
);

  logic [CNT_W-1:0] mem [INDEX_SPACE];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ design/fixed_block_pool_allocator_top.sv @@
// free, init, no-op and fresh-block or empty-pool allocate requests strobe done in the
// cycle after acceptance; an allocate that pops a freed block passes through the pop state
// (one link memory read), strobing done as it leaves; one request per cycle while busy is low
// the result strobe cannot be stalled; a new request may be taken while done is high
// reset (rst, synchronous): empty freed stack, counters zero, pool size 256
`default_nettype none

`include "fixed_block_pool_allocator_top_assert.svh"

module fixed_block_pool_allocator_top
  import fbpa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  // request channel
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       command,
  input  wire logic [IDX_W-1:0] block_index,
  // result channel
  output logic                  done,
  output logic                  granted,
  output logic      [IDX_W-1:0] granted_index,
  output logic                  error,
  output logic      [CNT_W-1:0] blocks_in_use,
  output logic      [CNT_W-1:0] peak_in_use,
  // pool size register
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] block_count
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_POP  = 1'b1;

  logic             state;
  logic [CNT_W-1:0] count_setting;   // last written pool size
  logic [CNT_W-1:0] capacity;        // pool size latched at init
  logic [CNT_W-1:0] freed_head;      // top of the freed-block stack
  logic [CNT_W-1:0] fresh_mark;      // next block never handed out
  logic [CNT_W-1:0] use_count;
  logic [CNT_W-1:0] peak_count;

  logic             accept;
  logic             free_ok;
  logic             stack_empty;
  logic [CNT_W-1:0] use_inc;
  link_wr_t         link_wr;
  logic [CNT_W-1:0] link_rd;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  assign busy          = (state == ST_POP);
  assign accept        = start && !busy;
  assign stack_empty   = (freed_head == LIST_EMPTY);
  assign blocks_in_use = use_count;
  assign peak_in_use   = peak_count;

  // free is rejected with nothing in use or an index beyond the pool
  assign free_ok = (use_count != '0) && ({1'b0, block_index} < capacity);

  // usage after a grant, saturating
  assign use_inc = (use_count < COUNT_SAT) ? use_count + 1'b1 : use_count;

  // free pushes: the freed block links to the old head
  always_comb begin
    link_wr.en   = accept && (command == CMD_FREE) && free_ok;
    link_wr.addr = block_index;
    link_wr.data = freed_head;
  end

  // the read at the head is issued every cycle; only the pop uses it
  fbpa_link_ram u_link_ram (
    .clk     (clk),
    .wr      (link_wr),
    .rd_addr (freed_head[IDX_W-1:0]),
    .rd_data (link_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count_setting <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      count_setting <= block_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      capacity      <= (COUNT_RESET < CAP_MAX) ? COUNT_RESET : CAP_MAX;
      freed_head    <= LIST_EMPTY;
      fresh_mark    <= '0;
      use_count     <= '0;
      peak_count    <= '0;
      done          <= 1'b0;
      granted       <= 1'b0;
      granted_index <= '0;
      error         <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            granted       <= 1'b0;
            granted_index <= '0;
            error         <= 1'b0;
            unique case (command)
              CMD_ALLOC: begin
                if (!stack_empty) begin
                  // link data for the head arrives next cycle
                  state <= ST_POP;
                end else begin
                  done <= 1'b1;
                  if (fresh_mark < capacity) begin
                    granted       <= 1'b1;
                    granted_index <= fresh_mark[IDX_W-1:0];
                    fresh_mark    <= fresh_mark + 1'b1;
                    use_count     <= use_inc;
                    if (peak_count < use_inc) begin
                      peak_count <= use_inc;
                    end
                  end
                end
              end
              CMD_FREE: begin
                done <= 1'b1;
                if (free_ok) begin
                  freed_head <= {1'b0, block_index};
                  use_count  <= use_count - 1'b1;
                end else begin
                  error <= 1'b1;
                end
              end
              CMD_INIT: begin
                done       <= 1'b1;
                capacity   <= (count_setting < CAP_MAX) ? count_setting : CAP_MAX;
                freed_head <= LIST_EMPTY;
                fresh_mark <= '0;
                use_count  <= '0;
                peak_count <= '0;
              end
              CMD_NOP: begin
                done <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_POP: begin
          // pop the freed stack with the link just read
          state         <= ST_IDLE;
          done          <= 1'b1;
          granted       <= 1'b1;
          granted_index <= freed_head[IDX_W-1:0];
          freed_head    <= link_rd;
          use_count     <= use_inc;
          if (peak_count < use_inc) begin
            peak_count <= use_inc;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // no result is shown while a pop is in flight
  `FBPA_ASSERT_NOW(a_busy_no_done, busy, !done, "result strobe during pop")
  // a pop always ends in a grant on the next cycle
  `FBPA_ASSERT_NEXT(a_pop_grants, busy, done && granted && !busy, "pop did not grant")
  // a grant never carries an error
  `FBPA_ASSERT_NOW(a_grant_no_err, done && granted, !error, "grant flagged as error")
  // peak usage never trails current usage
  `FBPA_ASSERT_NOW(a_peak_bound, 1'b1, peak_in_use >= blocks_in_use, "peak below usage")

endmodule

`default_nettype wire

@@ verif/tb_fixed_block_pool_allocator_top.sv @@
class pool_tracker;
  typedef logic [fbpa_pkg::CNT_W-1:0] cnt_t;
  typedef logic [fbpa_pkg::IDX_W-1:0] idx_t;

  typedef struct {
    logic granted;
    idx_t grant_idx;
    logic err;
    cnt_t in_use;
    cnt_t peak;
  } pool_result_t;

  cnt_t links[fbpa_pkg::INDEX_SPACE];
  cnt_t head;
  cnt_t fresh;
  cnt_t in_use;
  cnt_t peak;
  cnt_t capacity;
  cnt_t size_reg;
  idx_t held[$];
  pool_result_t owed[$];
  int mismatches;

  function new();
    foreach (links[i]) links[i] = '0;
    size_reg = fbpa_pkg::COUNT_RESET;
    mismatches = 0;
    rebuild();
  endfunction

  function void rebuild();
    capacity = (size_reg > fbpa_pkg::CAP_MAX) ? fbpa_pkg::CAP_MAX : size_reg;
    head = fbpa_pkg::LIST_EMPTY;
    fresh = '0;
    in_use = '0;
    peak = '0;
    held.delete();
  endfunction

  function void set_pool_size(cnt_t v);
    size_reg = v;
  endfunction

  function int pending();
    return owed.size();
  endfunction

  function int held_count();
    return held.size();
  endfunction

  function idx_t pick_held();
    return held[$urandom_range(0, held.size() - 1)];
  endfunction

  function void note_request(logic [1:0] cmd, idx_t idx);
    pool_result_t res;
    int i;
    res = '{granted: 1'b0, grant_idx: '0, err: 1'b0, in_use: '0, peak: '0};
    case (cmd)
      fbpa_pkg::CMD_ALLOC: begin
        if (head != fbpa_pkg::LIST_EMPTY) begin
          res.granted = 1'b1;
          res.grant_idx = head[fbpa_pkg::IDX_W-1:0];
          head = links[head[fbpa_pkg::IDX_W-1:0]];
        end else if (fresh < capacity) begin
          res.granted = 1'b1;
          res.grant_idx = fresh[fbpa_pkg::IDX_W-1:0];
          fresh = fresh + 1'b1;
        end
        if (res.granted) begin
          if (in_use < fbpa_pkg::COUNT_SAT) in_use = in_use + 1'b1;
          if (peak < in_use) peak = in_use;
          held.push_back(res.grant_idx);
        end
      end
      fbpa_pkg::CMD_FREE: begin
        if (in_use == '0 || {1'b0, idx} >= capacity) begin
          res.err = 1'b1;
        end else begin
          links[idx] = head;
          head = {1'b0, idx};
          in_use = in_use - 1'b1;
          for (i = 0; i < held.size(); i++) begin
            if (held[i] == idx) begin
              held.delete(i);
              break;
            end
          end
        end
      end
      fbpa_pkg::CMD_INIT: rebuild();
      default: ;
    endcase
    res.in_use = in_use;
    res.peak = peak;
    owed.push_back(res);
  endfunction

  task report(string msg);
    mismatches++;
    if (mismatches <= 40) $display("pool mismatch at %0t: %s", $time, msg);
  endtask

  task check_result(logic g, idx_t gi, logic e, cnt_t u, cnt_t p);
    pool_result_t want;
    if (owed.size() == 0) begin
      report("result with no request outstanding");
      return;
    end
    want = owed.pop_front();
    if (g !== want.granted)
      report($sformatf("granted %b, want %b", g, want.granted));
    if (gi !== want.grant_idx)
      report($sformatf("granted_index %0d, want %0d", gi, want.grant_idx));
    if (e !== want.err)
      report($sformatf("error %b, want %b", e, want.err));
    if (u !== want.in_use)
      report($sformatf("blocks_in_use %0d, want %0d", u, want.in_use));
    if (p !== want.peak)
      report($sformatf("peak_in_use %0d, want %0d", p, want.peak));
  endtask
endclass

module tb_fixed_block_pool_allocator_top;
  import fbpa_pkg::*;

  // watchdog bound, far above the length of the slowest run
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1350;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] command = CMD_NOP;
  logic [IDX_W-1:0] block_index = '0;
  logic cfg_valid = 1'b0;
  logic [CNT_W-1:0] block_count = COUNT_RESET;

  logic busy;
  logic done;
  logic granted;
  logic [IDX_W-1:0] granted_index;
  logic error;
  logic [CNT_W-1:0] blocks_in_use;
  logic [CNT_W-1:0] peak_in_use;
  logic cfg_ready;

  pool_tracker pool = new();
  bit no_gaps = 1'b0;
  int unsigned cycles = 0;

  fixed_block_pool_allocator_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .block_index(block_index),
    .done(done),
    .granted(granted),
    .granted_index(granted_index),
    .error(error),
    .blocks_in_use(blocks_in_use),
    .peak_in_use(peak_in_use),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .block_count(block_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog plus result checking, sampled on the rising edge
  // the done strobe cannot be held off, so every high cycle is one result
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_fixed_block_pool_allocator_top NOT OK");
      $finish;
    end
    if (!rst && done === 1'b1)
      pool.check_result(granted, granted_index, error, blocks_in_use, peak_in_use);
  end

  // random sender gap, skipped during the gap-free stretch
  task automatic sender_gap();
    int n;
    if (!no_gaps && $urandom_range(0, 99) < 10) begin
      n = $urandom_range(1, 5);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // one request: hold start until an edge with busy low takes it
  // start stays high on return so back-to-back requests need no extra step
  task automatic send(input logic [1:0] cmd, input logic [IDX_W-1:0] idx);
    sender_gap();
    start <= 1'b1;
    command <= cmd;
    block_index <= idx;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pool.note_request(cmd, idx);
  endtask

  // stop sending, wait out every outstanding result, then the pop latency
  task automatic settle();
    int waited;
    start <= 1'b0;
    waited = 0;
    while (pool.pending() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  // pool size register write, only ever issued while the block is idle
  task automatic write_pool_size(input logic [CNT_W-1:0] v);
    cfg_valid <= 1'b1;
    block_count <= v;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    pool.set_pool_size(v);
    cfg_valid <= 1'b0;
  endtask

  // mostly small pools so they fill and empty, some empty, full and oversized
  function automatic logic [CNT_W-1:0] pick_pool_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CAP_MAX;
      2: return CNT_W'($urandom_range(257, 511));
      default: return CNT_W'($urandom_range(1, 24));
    endcase
  endfunction

  // frees mostly hand back a block still held, the rest are random indexes
  // which covers out-of-range and not-allocated frees
  task automatic send_random(input int alloc_pct);
    int r;
    logic [IDX_W-1:0] idx;
    r = $urandom_range(0, 99);
    idx = IDX_W'($urandom_range(0, 255));
    if (r < alloc_pct) begin
      send(CMD_ALLOC, idx);
    end else if (r < 94) begin
      if (pool.held_count() > 0 && $urandom_range(0, 9) != 0) idx = pool.pick_held();
      send(CMD_FREE, idx);
    end else if (r < 97) begin
      send(CMD_NOP, idx);
    end else begin
      send(CMD_INIT, idx);
    end
  endtask

  initial begin
    int random_sent;
    int phase;
    int n;
    int alloc_pct;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, full pool of 256 from reset
    send(CMD_FREE, 8'd0);        // free with nothing in use
    send(CMD_ALLOC, 8'hFF);      // fresh blocks in ascending order
    send(CMD_ALLOC, 8'd0);
    send(CMD_ALLOC, 8'd0);
    send(CMD_FREE, 8'hFF);       // top index, never handed out but in range
    send(CMD_ALLOC, 8'd0);       // comes straight back out
    send(CMD_FREE, 8'd1);
    send(CMD_FREE, 8'd0);
    send(CMD_ALLOC, 8'd0);       // last freed first
    send(CMD_ALLOC, 8'd0);
    send(CMD_NOP, 8'hAA);        // unused command only reports statistics
    send(CMD_INIT, 8'h55);
    settle();

    // two-block pool: empty pool, out-of-range free, double free
    write_pool_size(9'd2);
    send(CMD_INIT, 8'd0);
    send(CMD_ALLOC, 8'd0);
    send(CMD_ALLOC, 8'd0);
    send(CMD_ALLOC, 8'd0);
    send(CMD_FREE, 8'd2);
    send(CMD_FREE, 8'd1);
    send(CMD_FREE, 8'd1);
    send(CMD_ALLOC, 8'd0);
    send(CMD_ALLOC, 8'd0);       // same block granted twice
    settle();

    // zero-size pool
    write_pool_size(9'd0);
    send(CMD_INIT, 8'd0);
    send(CMD_ALLOC, 8'd0);
    send(CMD_FREE, 8'd0);
    settle();

    // oversized request saturates to the full pool
    write_pool_size(9'h1FF);
    send(CMD_INIT, 8'd0);
    send(CMD_ALLOC, 8'd0);
    settle();

    // random phases, each with its own pool size and alloc/free balance
    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      no_gaps = (phase == 1);
      write_pool_size(pick_pool_size());
      send(CMD_INIT, IDX_W'($urandom_range(0, 255)));
      random_sent++;
      n = (phase == 1) ? 150 : $urandom_range(40, 120);
      alloc_pct = $urandom_range(25, 75);
      repeat (n) begin
        send_random(alloc_pct);
        random_sent++;
        // occasional full drain in the middle of a phase
        if ($urandom_range(0, 99) == 0) settle();
      end
      settle();
      phase++;
    end

    if (pool.pending() != 0) pool.report("requests left without a result");
    if (pool.mismatches == 0) begin
      $display("tb_fixed_block_pool_allocator_top OK");
    end else begin
      $display("tb_fixed_block_pool_allocator_top NOT OK");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+design
design/fbpa_pkg.sv
design/fbpa_link_ram.sv
design/fixed_block_pool_allocator_top.sv
verif/tb_fixed_block_pool_allocator_top.sv
